@@ rtl/dvs_pkg.sv @@
// dvs_pkg: shared types, constants and helper functions for the drum voice synth
// no dependencies; imported by every module of the block except dvs_ram
`timescale 1ns / 1ps
`default_nettype none

package dvs_pkg;

	// parameter defaults
	localparam int SINE_DEPTH_DEF = 1024;
	localparam int ENV_FRAC_DEF   = 24;

	// stream and config port widths
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int STEP_W     = 25;
	localparam int VEL_W      = 16;
	localparam int SAMPLE_W   = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KICK_PHASE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SNARE_PHASE = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KICK_DECAY  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SNARE_DECAY = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HIHAT_DECAY = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PERC_DECAY  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH_DECAY = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_SEED  = 4'd7;

	// register reset values
	localparam logic [31:0]       RST_KICK_PHASE  = 32'd5368709;
	localparam logic [31:0]       RST_SNARE_PHASE = 32'd10737418;
	localparam logic [STEP_W-1:0] RST_KICK_DECAY  = 25'd1165;
	localparam logic [STEP_W-1:0] RST_SNARE_DECAY = 25'd1748;
	localparam logic [STEP_W-1:0] RST_HIHAT_DECAY = 25'd6991;
	localparam logic [STEP_W-1:0] RST_PERC_DECAY  = 25'd3495;
	localparam logic [STEP_W-1:0] RST_PITCH_DECAY = 25'd6991;
	localparam logic [31:0]       RST_NOISE_SEED  = 32'd1;

	// arithmetic constants
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [31:0] LFSR_MASK   = 32'h80200003;
	localparam logic [14:0] C_TONE      = 15'd9830;
	localparam logic [14:0] C_SNARE     = 15'd22938;
	localparam logic [14:0] C_HALF      = 15'd16384;
	localparam logic [VEL_W-1:0] VEL_MAX = 16'd32768;

	// constant divider: 32-bit dividend, 4 quotient bits per cycle
	localparam int DIV_W     = 32;
	localparam int DIV_STEPS = 4;
	localparam int DIV_CNT_W = $clog2(DIV_W / DIV_STEPS);

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_TRIG = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		VT_KICK  = 2'd0,
		VT_SNARE = 2'd1,
		VT_HIHAT = 2'd2,
		VT_PERC  = 2'd3
	} voice_type_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
	} mul_req_t;

	typedef enum logic [3:0] {
		INIT_MX,
		INIT_X,
		INIT_X2IS,
		INIT_X2,
		INIT_TM,
		INIT_TD,
		INIT_DW,
		INIT_WR,
		INIT_DONE
	} init_state_t;

	typedef enum logic [3:0] {
		V_IDLE,
		V_KTURN,
		V_KIDX,
		V_SIDX,
		V_RD,
		V_RDW,
		V_QMUL,
		V_QRES,
		V_M1,
		V_M2,
		V_M3,
		V_OUT
	} voice_state_t;

	// taylor term divisors for x^3, x^5, x^7, x^9
	function automatic logic [6:0] taylor_div(input logic [1:0] k);
		logic [6:0] d;
		case (k)
			2'd0: d = 7'd6;
			2'd1: d = 7'd20;
			2'd2: d = 7'd42;
			default: d = 7'd72;
		endcase
		return d;
	endfunction

	// galois lfsr, one step
	function automatic logic [31:0] lfsr_next(input logic [31:0] s);
		logic [31:0] n;
		n = {1'b0, s[31:1]};
		if (s[0]) begin
			n = n ^ LFSR_MASK;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

@@ rtl/dvs_ram.sv @@
// dvs_ram: generic single write port, single read port ram with registered read
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module dvs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/dvs_mul.sv @@
// dvs_mul: shared 32x32 unsigned multiplier with registered product
// depends on dvs_pkg (mul_req_t)
`timescale 1ns / 1ps
`default_nettype none

module dvs_mul
	import dvs_pkg::*;
(
	input  wire logic     clk,
	input  wire mul_req_t req,
	output logic [63:0]   prod
);

	always_ff @(posedge clk) begin
		prod <= 64'(req.a) * 64'(req.b);
	end

endmodule

`default_nettype wire

@@ rtl/dvs_div.sv @@
// dvs_div: radix-16 restoring divider for small constant divisors (up to 7 bits)
// depends on dvs_pkg (DIV_W, DIV_STEPS, DIV_CNT_W)
`timescale 1ns / 1ps
`default_nettype none

module dvs_div
	import dvs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [6:0]       divisor,
	output logic                  busy,
	output logic      [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0]     work_q;
	logic [6:0]           rem_q;
	logic [6:0]           div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DIV_W-1:0]     work_d;
	logic [6:0]           rem_d;

	// dividend bits shift out the top, quotient bits shift in the bottom
	always_comb begin
		logic [7:0] rr;
		work_d = work_q;
		rem_d  = rem_q;
		for (int j = 0; j < DIV_STEPS; j++) begin
			rr     = {rem_d, work_d[DIV_W-1]};
			work_d = {work_d[DIV_W-2:0], 1'b0};
			if (rr >= {1'b0, div_q}) begin
				rr        = rr - {1'b0, div_q};
				work_d[0] = 1'b1;
			end
			rem_d = rr[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_W / DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			work_q <= work_d;
			rem_q  <= rem_d;
		end
	end

	assign busy     = busy_q;
	assign quotient = work_q;

endmodule

`default_nettype wire

@@ rtl/dvs_sine_init.sv @@
// dvs_sine_init: after reset builds the sine table entry by entry with a taylor series
// depends on dvs_pkg, dvs_div; drives the shared multiplier and the table write port
`timescale 1ns / 1ps
`default_nettype none

module dvs_sine_init
	import dvs_pkg::*;
#(
	parameter int DEPTH = SINE_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [63:0]              prod,
	output mul_req_t                      mul_req,
	output logic                          wr_en,
	output logic      [$clog2(DEPTH)-1:0] wr_addr,
	output logic      [SAMPLE_W-1:0]      wr_data,
	output logic                          done
);

	localparam int AW = $clog2(DEPTH);
	localparam int RW = $clog2(DEPTH) + 1;
	localparam longint unsigned TWO32 = 64'd1 << 32;
	localparam logic [31:0]   STEP_Q = 32'(TWO32 / DEPTH);
	localparam logic [RW-1:0] STEP_R = RW'(TWO32 % DEPTH);

	init_state_t    state_q, state_d;
	logic [31:0]    t_q;
	logic [RW-1:0]  trem_q;
	logic [AW-1:0]  idx_q;
	logic [31:0]    x_q;
	logic [31:0]    x2_q;
	logic [31:0]    term_q;
	logic [31:0]    acc_q;
	logic [1:0]     k_q;

	logic [30:0]    frac;
	logic [30:0]    fold;
	logic [31:0]    prod_sh;
	logic [RW-1:0]  trem_sum;
	logic [17:0]    acc_rnd;
	logic [15:0]    mag;
	logic           div_start;
	logic           div_busy;
	logic [31:0]    div_quo;
	logic           last;

	// fold the phase onto the first quarter wave
	assign frac    = {1'b0, t_q[29:0]};
	assign fold    = t_q[30] ? (31'h40000000 - frac) : frac;
	assign prod_sh = prod[61:30];
	assign last    = (idx_q == AW'(DEPTH - 1));

	assign trem_sum = trem_q + STEP_R;
	assign acc_rnd  = 18'((33'(acc_q) + 33'd16384) >> 15);
	assign mag      = (acc_rnd > 18'd32767) ? 16'h7FFF : {1'b0, acc_rnd[14:0]};

	assign wr_addr = idx_q;
	assign wr_data = t_q[31] ? (16'd0 - mag) : mag;
	assign done    = (state_q == INIT_DONE);

	dvs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_sh),
		.divisor  (taylor_div(k_q)),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= INIT_MX;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mul_req   = '0;
		div_start = 1'b0;
		wr_en     = 1'b0;
		case (state_q)
			INIT_MX: begin
				mul_req.a = {1'b0, fold};
				mul_req.b = HALF_PI_Q30;
				state_d   = INIT_X;
			end
			INIT_X: begin
				state_d = INIT_X2IS;
			end
			INIT_X2IS: begin
				mul_req.a = x_q;
				mul_req.b = x_q;
				state_d   = INIT_X2;
			end
			INIT_X2: begin
				state_d = INIT_TM;
			end
			INIT_TM: begin
				mul_req.a = term_q;
				mul_req.b = x2_q;
				state_d   = INIT_TD;
			end
			INIT_TD: begin
				div_start = 1'b1;
				state_d   = INIT_DW;
			end
			INIT_DW: begin
				if (!div_busy) begin
					state_d = (k_q == 2'd3) ? INIT_WR : INIT_TM;
				end
			end
			INIT_WR: begin
				wr_en   = 1'b1;
				state_d = last ? INIT_DONE : INIT_MX;
			end
			INIT_DONE: begin
				state_d = INIT_DONE;
			end
			default: begin
				state_d = INIT_MX;
			end
		endcase
	end

	// table position: t = floor(i * 2^32 / DEPTH), stepped with a remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q    <= '0;
			trem_q <= '0;
			idx_q  <= '0;
			k_q    <= '0;
		end else begin
			if (state_q == INIT_WR) begin
				idx_q <= idx_q + 1'b1;
				if (trem_sum >= RW'(DEPTH)) begin
					t_q    <= t_q + STEP_Q + 32'd1;
					trem_q <= trem_sum - RW'(DEPTH);
				end else begin
					t_q    <= t_q + STEP_Q;
					trem_q <= trem_sum;
				end
			end
			if (state_q == INIT_X2) begin
				k_q <= '0;
			end else if (state_q == INIT_DW && !div_busy) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			INIT_X: begin
				x_q    <= prod_sh;
				term_q <= prod_sh;
				acc_q  <= prod_sh;
			end
			INIT_X2: begin
				x2_q <= prod_sh;
			end
			INIT_DW: begin
				if (!div_busy) begin
					term_q <= div_quo;
					// alternate signs: - x^3/3! + x^5/5! - x^7/7! + x^9/9!
					acc_q  <= k_q[0] ? (acc_q + div_quo) : (acc_q - div_quo);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/drum_voice_synth.sv @@
// drum_voice_synth: one-voice drum synth; each tick beat on an active voice yields a sample.
// flow: a trigger or a tick on a silent voice gives no result; a sounding tick steps through
// its states (hihat, perc: QMUL, QRES, M1-M3; kick: KTURN, KIDX, RD, RDW, M1-M3; snare: SIDX,
// RD, RDW, QMUL/QRES for tone then mix, M1-M3) and loads the output register in V_OUT, which
// waits while the output is held; the next beat is accepted back in V_IDLE. reset: state clears
// and the sine table is built with s_axis_tready low; config writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none

module drum_voice_synth
	import dvs_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
	parameter int ENV_FRAC_BITS    = ENV_FRAC_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // velocity[15:0], voice_type[17:16], 0
	input  wire logic [0:0]            s_axis_tuser,  // operation[0]
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [OUT_DATA_W-1:0] m_axis_tdata,  // sample[15:0], voice_active[16], 0
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW    = $clog2(SINE_TABLE_DEPTH);
	localparam int ENV_W = ENV_FRAC_BITS + 1;
	localparam int CMP_W = (ENV_W > STEP_W) ? ENV_W : STEP_W;
	localparam logic [ENV_W-1:0] ENV_ONE   = ENV_W'(1) << ENV_FRAC_BITS;
	localparam logic [63:0]      RND_FINAL = 64'd1 << (ENV_FRAC_BITS + 14);

	// config registers
	logic [31:0]       kick_phase_q;
	logic [31:0]       snare_phase_q;
	logic [STEP_W-1:0] kick_decay_q;
	logic [STEP_W-1:0] snare_decay_q;
	logic [STEP_W-1:0] hihat_decay_q;
	logic [STEP_W-1:0] perc_decay_q;
	logic [STEP_W-1:0] pitch_decay_q;

	// voice state
	voice_state_t      state_q, state_d;
	logic              active_q;
	voice_type_t       type_q;
	logic [VEL_W-1:0]  level_q;
	logic [31:0]       phase_q;
	logic [ENV_W-1:0]  amp_q;
	logic [ENV_W-1:0]  pitch_q;
	logic [31:0]       lfsr_q;

	// per-tick working registers
	logic signed [16:0] v_q;
	logic signed [17:0] qsrc_q;
	logic [14:0]        qc_q;
	logic signed [15:0] noise_q;
	logic               tone_q;
	logic [SAMPLE_W-1:0] res_q;
	logic               m_valid_q;
	logic [SAMPLE_W-1:0] m_sample_q;
	logic               m_active_q;

	// shared units
	mul_req_t          init_req, voice_req, mul_req;
	logic [63:0]       prod_q;
	logic              init_done;
	logic              tbl_wr_en;
	logic [AW-1:0]     tbl_wr_addr;
	logic [15:0]       tbl_wr_data;
	logic              tbl_rd_en;
	logic [15:0]       tbl_rd_data;

	logic              in_acc;
	logic              cfg_acc;
	logic              out_load;
	logic [31:0]       lfsr_n;
	logic [VEL_W-1:0]  vel_sat;
	logic [31:0]       factor;
	logic [16:0]       v_abs;
	logic [16:0]       q_abs;
	logic [16:0]       q_mag;
	logic signed [17:0] q_val;
	logic [63:0]       fin_sum;
	logic [16:0]       fin_mag;
	logic [SAMPLE_W-1:0] sample_n;
	logic [STEP_W-1:0] amp_step;
	logic              amp_end;
	logic              pitch_end;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_acc    = s_axis_tvalid && s_axis_tready;

	assign lfsr_n  = lfsr_next(lfsr_q);
	assign vel_sat = (s_axis_tdata[15:0] > VEL_MAX) ? VEL_MAX : s_axis_tdata[15:0];
	assign factor  = 32'(ENV_ONE) + 32'({pitch_q, 1'b0});
	assign v_abs   = v_q[16] ? (17'd0 - 17'(v_q)) : 17'(v_q);
	assign q_abs   = qsrc_q[17] ? 17'(18'd0 - 18'(qsrc_q)) : 17'(qsrc_q);
	assign q_mag   = 17'((prod_q + 64'd16384) >> 15);
	assign q_val   = qsrc_q[17] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

	// final scale: round, clamp magnitude to 1.0, then clamp the positive side
	assign fin_sum = prod_q + RND_FINAL;
	always_comb begin
		logic [63:0] r;
		r       = fin_sum >> (ENV_FRAC_BITS + 15);
		fin_mag = (r > 64'd32768) ? 17'd32768 : r[16:0];
		if (v_q[16]) begin
			sample_n = 16'(17'd0 - fin_mag);
		end else begin
			sample_n = (fin_mag > 17'd32767) ? 16'h7FFF : fin_mag[15:0];
		end
	end

	always_comb begin
		case (type_q)
			VT_KICK:  amp_step = kick_decay_q;
			VT_SNARE: amp_step = snare_decay_q;
			VT_HIHAT: amp_step = hihat_decay_q;
			default:  amp_step = perc_decay_q;
		endcase
	end

	assign amp_end   = (CMP_W'(amp_q) <= CMP_W'(amp_step));
	assign pitch_end = (CMP_W'(pitch_q) < CMP_W'(pitch_decay_q));

	dvs_sine_init #(
		.DEPTH (SINE_TABLE_DEPTH)
	) u_sine_init (
		.clk     (clk),
		.arst_n  (arst_n),
		.prod    (prod_q),
		.mul_req (init_req),
		.wr_en   (tbl_wr_en),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data),
		.done    (init_done)
	);

	assign mul_req = init_done ? voice_req : init_req;

	dvs_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod_q)
	);

	dvs_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (SINE_TABLE_DEPTH)
	) u_sine_ram (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data),
		.rd_en   (tbl_rd_en),
		.rd_addr (prod_q[32 +: AW]),
		.rd_data (tbl_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= V_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		voice_req     = '0;
		tbl_rd_en     = 1'b0;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			V_IDLE: begin
				s_axis_tready = init_done;
				if (in_acc && s_axis_tuser[0] == OP_TICK && active_q) begin
					case (type_q)
						VT_KICK:  state_d = V_KTURN;
						VT_SNARE: state_d = V_SIDX;
						default:  state_d = V_QMUL;
					endcase
				end
			end
			V_KTURN: begin
				voice_req.a = phase_q;
				voice_req.b = factor;
				state_d     = V_KIDX;
			end
			V_KIDX: begin
				// table index = (turns * depth) >> 32
				voice_req.a = prod_q[ENV_FRAC_BITS +: 32];
				voice_req.b = 32'(SINE_TABLE_DEPTH);
				state_d     = V_RD;
			end
			V_SIDX: begin
				voice_req.a = phase_q;
				voice_req.b = 32'(SINE_TABLE_DEPTH);
				state_d     = V_RD;
			end
			V_RD: begin
				tbl_rd_en = 1'b1;
				state_d   = V_RDW;
			end
			V_RDW: begin
				state_d = (type_q == VT_KICK) ? V_M1 : V_QMUL;
			end
			V_QMUL: begin
				voice_req.a = 32'(q_abs);
				voice_req.b = 32'(qc_q);
				state_d     = V_QRES;
			end
			V_QRES: begin
				state_d = tone_q ? V_QMUL : V_M1;
			end
			V_M1: begin
				voice_req.a = 32'(v_abs);
				voice_req.b = 32'(level_q);
				state_d     = V_M2;
			end
			V_M2: begin
				voice_req.a = prod_q[31:0];
				voice_req.b = 32'(amp_q);
				state_d     = V_M3;
			end
			V_M3: begin
				state_d = V_OUT;
			end
			V_OUT: begin
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = V_IDLE;
				end
			end
			default: begin
				state_d = V_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kick_phase_q  <= RST_KICK_PHASE;
			snare_phase_q <= RST_SNARE_PHASE;
			kick_decay_q  <= RST_KICK_DECAY;
			snare_decay_q <= RST_SNARE_DECAY;
			hihat_decay_q <= RST_HIHAT_DECAY;
			perc_decay_q  <= RST_PERC_DECAY;
			pitch_decay_q <= RST_PITCH_DECAY;
		end else if (cfg_acc) begin
			case (cfg_index)
				CFG_KICK_PHASE:  kick_phase_q  <= cfg_data;
				CFG_SNARE_PHASE: snare_phase_q <= cfg_data;
				CFG_KICK_DECAY:  kick_decay_q  <= cfg_data[STEP_W-1:0];
				CFG_SNARE_DECAY: snare_decay_q <= cfg_data[STEP_W-1:0];
				CFG_HIHAT_DECAY: hihat_decay_q <= cfg_data[STEP_W-1:0];
				CFG_PERC_DECAY:  perc_decay_q  <= cfg_data[STEP_W-1:0];
				CFG_PITCH_DECAY: pitch_decay_q <= cfg_data[STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			type_q    <= VT_KICK;
			level_q   <= '0;
			phase_q   <= '0;
			amp_q     <= '0;
			pitch_q   <= '0;
			lfsr_q    <= RST_NOISE_SEED;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_acc && cfg_index == CFG_NOISE_SEED) begin
				// a zero seed would lock the lfsr
				lfsr_q <= (cfg_data != 32'd0) ? cfg_data : 32'd1;
			end else if (state_q == V_IDLE && in_acc && s_axis_tuser[0] == OP_TICK &&
				active_q && type_q != VT_KICK) begin
				lfsr_q <= lfsr_n;
			end

			if (state_q == V_IDLE && in_acc && s_axis_tuser[0] == OP_TRIG) begin
				active_q <= 1'b1;
				type_q   <= voice_type_t'(s_axis_tdata[17:16]);
				level_q  <= vel_sat;
				phase_q  <= '0;
				amp_q    <= ENV_ONE;
				pitch_q  <= ENV_ONE;
			end

			if (state_q == V_M3) begin
				if (type_q == VT_KICK) begin
					phase_q <= phase_q + kick_phase_q;
					pitch_q <= pitch_end ? '0
						: ENV_W'(CMP_W'(pitch_q) - CMP_W'(pitch_decay_q));
				end else if (type_q == VT_SNARE) begin
					phase_q <= phase_q + snare_phase_q;
				end
				if (amp_end) begin
					amp_q    <= '0;
					active_q <= 1'b0;
				end else begin
					amp_q <= ENV_W'(CMP_W'(amp_q) - CMP_W'(amp_step));
				end
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			V_IDLE: begin
				noise_q <= $signed(lfsr_n[31:16]);
				qsrc_q  <= 18'($signed(lfsr_n[31:16]));
				qc_q    <= C_HALF;
				tone_q  <= (type_q == VT_SNARE);
			end
			V_RDW: begin
				v_q    <= 17'($signed(tbl_rd_data));
				qsrc_q <= 18'($signed(tbl_rd_data));
				qc_q   <= C_TONE;
			end
			V_QRES: begin
				if (tone_q) begin
					// snare: noise plus the scaled tone, then the 0.7 mix
					qsrc_q <= 18'(noise_q) + q_val;
					qc_q   <= C_SNARE;
					tone_q <= 1'b0;
				end else begin
					v_q <= 17'(q_val);
				end
			end
			V_M3: begin
				res_q <= sample_n;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_sample_q <= res_q;
			m_active_q <= active_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, m_active_q, m_sample_q};

endmodule

`default_nettype wire
